[sv/modbus_read_response_checker_unit_assert.svh]
// ----------------------------------------------------------------------------
// Modbus read response checker assertion macros
// Clocked assertion helpers that use clk_i and rst_ni of the including module.
// ----------------------------------------------------------------------------
`ifndef MODBUS_READ_RESPONSE_CHECKER_UNIT_ASSERT_SVH
`define MODBUS_READ_RESPONSE_CHECKER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MRRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MRRC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MRRC_ASSERT(lbl, prop, msg)
`define MRRC_NEVER(lbl, cond, msg)
`endif
`endif

[sv/mrrc_pkg.sv]
// ----------------------------------------------------------------------------
// Modbus read response checker package
// Shared constants, types and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package mrrc_pkg;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam int unsigned MIN_FRAME   = 5;
  localparam int unsigned HDR_DEPTH   = 7;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned EXC_BIT     = 7;

  localparam logic [7:0] RST_SLAVE   = 8'd1;
  localparam logic [6:0] RST_FUNC    = 7'd3;
  localparam logic [1:0] RST_REG_CNT = 2'd1;

  typedef enum logic [1:0] {
    CFG_SLAVE   = 2'd0,
    CFG_FUNC    = 2'd1,
    CFG_REG_CNT = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_INCOMPLETE = 3'd1,
    ST_CRC        = 3'd2,
    ST_SLAVE      = 3'd3,
    ST_FUNCTION   = 3'd4,
    ST_EXCEPTION  = 3'd5,
    ST_LENGTH     = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] slave;
    logic [6:0] func;
    logic [1:0] reg_cnt;
  } cfg_t;

  // Summary of one closed frame, handed from the front end to the back end.
  typedef struct packed {
    logic            short_frame;
    logic            crc_ok;
    logic            len_one;
    logic            len_two;
    logic [4:0]      frame_length;
    logic [6:0][7:0] hdr;
  } frame_sum_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[sv/mrrc_if.sv]
// ----------------------------------------------------------------------------
// Modbus read response checker channels
// Valid/ready channels for received bytes and for frame results.
// ----------------------------------------------------------------------------
interface mrrc_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrrc_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  exception_code;
  logic [31:0] register_value;
  logic [4:0]  frame_length;

  modport source (output valid, output status, output exception_code,
                  output register_value, output frame_length, input ready);
  modport sink (input valid, input status, input exception_code,
                input register_value, input frame_length, output ready);
endinterface

[sv/mrrc_front.sv]
// ----------------------------------------------------------------------------
// Modbus read response checker front end
// Takes bytes, runs the CRC, keeps header and tail, and summarizes each frame.
// ----------------------------------------------------------------------------
module mrrc_front #(
  parameter int unsigned FRAME_CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  mrrc_req_if.sink            req,
  input  mrrc_pkg::q_stat_t   q_stat_i,
  output logic                push_o,
  output mrrc_pkg::frame_sum_t sum_o
);

  localparam int unsigned CW = $clog2(FRAME_CAPACITY + 1);

  logic [CW-1:0]   cnt_q, cnt_d, cnt_new;
  logic [15:0]     crc_q, crc_d, crc_new;
  logic [7:0]      tail_q [2];
  logic [7:0]      tail0_new, tail1_new;
  logic [6:0][7:0] hdr_q, hdr_new;
  logic            accept, kept;

  assign req.ready = !q_stat_i.full;
  assign accept    = req.valid && req.ready;
  assign kept      = cnt_q < CW'(FRAME_CAPACITY);

  always_comb begin
    cnt_new   = kept ? cnt_q + CW'(1) : cnt_q;
    crc_new   = (kept && cnt_q >= CW'(2)) ? mrrc_pkg::crc_fold(crc_q, tail_q[0]) : crc_q;
    tail0_new = kept ? tail_q[1] : tail_q[0];
    tail1_new = kept ? req.rx_byte : tail_q[1];
    for (int i = 0; i < 7; i++) begin
      hdr_new[i] = (kept && cnt_q == CW'(i)) ? req.rx_byte : hdr_q[i];
    end
    cnt_d = cnt_q;
    crc_d = crc_q;
    if (accept) begin
      if (req.frame_end) begin
        cnt_d = '0;
        crc_d = mrrc_pkg::CRC_INIT;
      end else begin
        cnt_d = cnt_new;
        crc_d = crc_new;
      end
    end
  end

  always_comb begin
    push_o             = accept && req.frame_end;
    sum_o.short_frame  = cnt_new < CW'(mrrc_pkg::MIN_FRAME);
    sum_o.crc_ok       = crc_new == {tail1_new, tail0_new};
    sum_o.len_one      = cnt_new == CW'(mrrc_pkg::MIN_FRAME + 2);
    sum_o.len_two      = cnt_new == CW'(mrrc_pkg::MIN_FRAME + 4);
    sum_o.frame_length = 5'(cnt_new);
    sum_o.hdr          = hdr_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      crc_q <= mrrc_pkg::CRC_INIT;
    end else begin
      cnt_q <= cnt_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tail_q[0] <= tail0_new;
      tail_q[1] <= tail1_new;
      hdr_q     <= hdr_new;
    end
  end

endmodule

[sv/mrrc_queue.sv]
// ----------------------------------------------------------------------------
// Modbus read response checker frame queue
// Short first-in first-out buffer of frame summaries between front and back.
// ----------------------------------------------------------------------------
module mrrc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mrrc_pkg::frame_sum_t push_data_i,
  input  logic                 pop_i,
  output mrrc_pkg::frame_sum_t pop_data_o,
  output mrrc_pkg::q_stat_t    q_stat_o
);

  localparam int unsigned PW = $clog2(mrrc_pkg::QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(mrrc_pkg::QUEUE_DEPTH + 1);

  mrrc_pkg::frame_sum_t mem_q [mrrc_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] fill_q, fill_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(mrrc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(mrrc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + NW'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - NW'(1);
    end
  end

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign q_stat_o.full  = fill_q == NW'(mrrc_pkg::QUEUE_DEPTH);
  assign q_stat_o.empty = fill_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[sv/mrrc_back.sv]
// ----------------------------------------------------------------------------
// Modbus read response checker back end
// Runs the ordered frame checks and holds the result for the sink.
// ----------------------------------------------------------------------------
module mrrc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mrrc_pkg::cfg_t       cfg_i,
  input  mrrc_pkg::frame_sum_t sum_i,
  input  mrrc_pkg::q_stat_t    q_stat_i,
  output logic                 pop_o,
  mrrc_res_if.source           res
);

  logic              valid_q, valid_d;
  mrrc_pkg::status_e status_q, status_d;
  logic [7:0]        exc_q, exc_d;
  logic [31:0]       value_q, value_d;
  logic [4:0]        len_q;
  logic              len_ok;

  assign pop_o = !q_stat_i.empty && (!valid_q || res.ready);

  always_comb begin
    case (cfg_i.reg_cnt)
      2'd1:    len_ok = sum_i.len_one && sum_i.hdr[2] == 8'd2;
      2'd2:    len_ok = sum_i.len_two && sum_i.hdr[2] == 8'd4;
      default: len_ok = 1'b0;
    endcase
  end

  always_comb begin
    exc_d   = '0;
    value_d = '0;
    if (sum_i.short_frame) begin
      status_d = mrrc_pkg::ST_INCOMPLETE;
    end else if (!sum_i.crc_ok) begin
      status_d = mrrc_pkg::ST_CRC;
    end else if (sum_i.hdr[0] != cfg_i.slave) begin
      status_d = mrrc_pkg::ST_SLAVE;
    end else if (sum_i.hdr[1][6:0] != cfg_i.func) begin
      status_d = mrrc_pkg::ST_FUNCTION;
    end else if (sum_i.hdr[1][mrrc_pkg::EXC_BIT]) begin
      status_d = mrrc_pkg::ST_EXCEPTION;
      exc_d    = sum_i.hdr[2];
    end else if (!len_ok) begin
      status_d = mrrc_pkg::ST_LENGTH;
    end else begin
      status_d = mrrc_pkg::ST_OK;
      if (cfg_i.reg_cnt == 2'd1) begin
        value_d = {16'h0000, sum_i.hdr[3], sum_i.hdr[4]};
      end else begin
        value_d = {sum_i.hdr[3], sum_i.hdr[4], sum_i.hdr[5], sum_i.hdr[6]};
      end
    end
    valid_d = pop_o ? 1'b1 : (res.ready ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= status_d;
      exc_q    <= exc_d;
      value_q  <= value_d;
      len_q    <= sum_i.frame_length;
    end
  end

  assign res.valid          = valid_q;
  assign res.status         = status_q;
  assign res.exception_code = exc_q;
  assign res.register_value = value_q;
  assign res.frame_length   = len_q;

endmodule

[sv/modbus_read_response_checker_unit.sv]
// ----------------------------------------------------------------------------
// Modbus read response checker
// Throughput: one byte per cycle while the summary queue is not full; a
// closing byte may follow the previous one. Each result is registered: the
// frame summary passes the summary queue, then the back end output register.
// Reset clears byte count, queue and result valid, presets the CRC, and loads
// the configuration defaults (slave 1, function 3, one register).
// ----------------------------------------------------------------------------
`include "modbus_read_response_checker_unit_assert.svh"

module modbus_read_response_checker_unit #(
  parameter int unsigned FRAME_CAPACITY = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrrc_req_if.sink   req,
  mrrc_res_if.source res,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  mrrc_pkg::cfg_t       cfg_q, cfg_d;
  mrrc_pkg::frame_sum_t push_sum, head_sum;
  mrrc_pkg::q_stat_t    q_stat;
  logic                 q_push, q_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        mrrc_pkg::CFG_SLAVE:   cfg_d.slave   = cfg_data_i;
        mrrc_pkg::CFG_FUNC:    cfg_d.func    = cfg_data_i[6:0];
        mrrc_pkg::CFG_REG_CNT: cfg_d.reg_cnt = cfg_data_i[1:0];
        default:               cfg_d         = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave   <= mrrc_pkg::RST_SLAVE;
      cfg_q.func    <= mrrc_pkg::RST_FUNC;
      cfg_q.reg_cnt <= mrrc_pkg::RST_REG_CNT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mrrc_front #(
    .FRAME_CAPACITY(FRAME_CAPACITY)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req),
    .q_stat_i (q_stat),
    .push_o   (q_push),
    .sum_o    (push_sum)
  );

  mrrc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_sum),
    .pop_i       (q_pop),
    .pop_data_o  (head_sum),
    .q_stat_o    (q_stat)
  );

  mrrc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .sum_i    (head_sum),
    .q_stat_i (q_stat),
    .pop_o    (q_pop),
    .res      (res)
  );

  `MRRC_NEVER(a_push_full, q_push && q_stat.full, "frame summary pushed into a full queue")
  `MRRC_NEVER(a_pop_empty, q_pop && q_stat.empty, "frame summary popped from an empty queue")
  `MRRC_ASSERT(a_value_ok, res.valid && res.status != mrrc_pkg::ST_OK |-> res.register_value == 32'd0, "register value set on a failed frame")
  `MRRC_ASSERT(a_exc_code, res.valid && res.status != mrrc_pkg::ST_EXCEPTION |-> res.exception_code == 8'd0, "exception code set without an exception")

endmodule
